// ===== hdl/cmc_pkg.sv =====
// cmc_pkg: shared types, register codes and constants of the color matrix converter
// no dependencies; imported by cmc_channel, color_matrix_3x3_converter and its test
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VEC_W = 17;
   localparam int ROW_W = 48;
   localparam int CSR_IDX_W = 3;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF = 12;

   localparam int LUMA_OFFSET = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int MAX8 = 255;
   localparam int MAX16 = 65535;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 3'd4;

   localparam logic [ROW_W-1:0] ROW0_RESET = 48'd4096;
   localparam logic [ROW_W-1:0] ROW1_RESET = 48'd268435456;
   localparam logic [ROW_W-1:0] ROW2_RESET = 48'd17592186044416;

   typedef enum logic [1:0] {
      FMT_UYVY = 2'd0,
      FMT_RGB  = 2'd1,
      FMT_RG48 = 2'd2
   } format_type;

   typedef logic signed [VEC_W-1:0] vec_type;

   typedef struct packed {
      logic [15:0] sample_0;
      logic [15:0] sample_1;
      logic [15:0] sample_2;
      logic [7:0]  sample_3;
   } req_type;

   typedef struct packed {
      logic [15:0] chan_0;
      logic [15:0] chan_1;
      logic [15:0] chan_2;
      logic        last_of_group;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic clamp;
      logic wide;
   } stage_type;

   typedef struct packed {
      logic clamp;
      logic wide;
   } sat_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/cmc_channel.sv =====
// cmc_channel: one output channel: products, sum, truncation toward zero, clamp/wrap
// depends on cmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmc_channel #(
   parameter int COEF_WIDTH = cmc_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = cmc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic [cmc_pkg::ROW_W-1:0]        row,
   input  wire cmc_pkg::vec_type                 vec [3],
   input  wire cmc_pkg::sat_ctl_type             sat_ctl,
   output logic [cmc_pkg::SAMPLE_W-1:0]          chan
);
   import cmc_pkg::*;

   localparam int PackW = (3 * COEF_WIDTH > ROW_W) ? 3 * COEF_WIDTH : ROW_W;
   localparam int ProdW = COEF_WIDTH + VEC_W;
   localparam int SumW = ProdW + 2;
   localparam int QuoW = SumW - FRAC_BITS;
   localparam int CmpW = (QuoW > SAMPLE_W + 1) ? QuoW : SAMPLE_W + 1;

   logic [PackW-1:0]             row_ext;
   logic signed [COEF_WIDTH-1:0] coef [3];
   logic signed [ProdW-1:0]      prod_in [3];
   logic signed [ProdW-1:0]      prod_ff [3];
   logic signed [SumW-1:0]       sum_in;
   logic signed [SumW-1:0]       sum_ff;
   logic signed [SumW-1:0]       shifted;
   logic                         round_up;
   logic signed [QuoW-1:0]       quo_in;
   logic signed [QuoW-1:0]       quo_ff;
   logic signed [CmpW-1:0]       quo_x;
   logic [CmpW-1:0]              max_x;
   logic [SAMPLE_W-1:0]          chan_in;
   logic [SAMPLE_W-1:0]          chan_ff;

   assign row_ext = PackW'(row);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef[k] = row_ext[k*COEF_WIDTH +: COEF_WIDTH];
         prod_in[k] = ProdW'(coef[k]) * ProdW'(vec[k]);
      end
   end

   assign sum_in = SumW'(prod_ff[0]) + SumW'(prod_ff[1]) + SumW'(prod_ff[2]);

   // arithmetic shift floors, so bump negative values with a nonzero fraction
   assign shifted = sum_ff >>> FRAC_BITS;
   assign round_up = sum_ff[SumW-1] & (|sum_ff[FRAC_BITS-1:0]);
   assign quo_in = QuoW'(shifted) + QuoW'(round_up);

   assign quo_x = CmpW'(quo_ff);
   assign max_x = sat_ctl.wide ? CmpW'(MAX16) : CmpW'(MAX8);

   always_comb begin
      if (sat_ctl.clamp) begin
         if (quo_x[CmpW-1]) begin
            chan_in = '0;
         end else if ($unsigned(quo_x) > max_x) begin
            chan_in = max_x[SAMPLE_W-1:0];
         end else begin
            chan_in = quo_x[SAMPLE_W-1:0];
         end
      end else begin
         chan_in = quo_x[SAMPLE_W-1:0] & max_x[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= prod_in[k];
      end
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      chan_ff <= chan_in;
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

// ===== hdl/color_matrix_3x3_converter.sv =====
// color_matrix_3x3_converter: top level with register file, pixel entry and control pipeline
// depends on cmc_pkg and cmc_channel
//
// usage:
//   input: a transaction is taken at a rising edge with start high and busy low;
//   req_data carries sample_0..sample_3. A UYVY transaction yields two pixels,
//   RGB and RG48 one each; format code 3 takes the transaction and yields none.
//   output: each result sits on rsp_data for one cycle with rsp_strobe high;
//   last_of_group marks the final result of a transaction.
//   csr: csr_valid/csr_ready write csr_data to register csr_index; csr_ready is
//   always high. Write only while no transaction is in flight.
// timing:
//   a result passes the entry, product, sum, truncate and output registers before
//   it strobes; the second UYVY pixel follows in the cycle after the first. RGB
//   and RG48 take one transaction per cycle; UYVY blocks the next one, since both
//   pixels share the multiplier array and busy is high while the second pixel enters.
//   stages: pixel entry, products, sum, truncate, saturate/output register.
// reset: clears busy and all stage valid bits, loads identity coefficients,
//   clamping on and RGB format. The receiver cannot stall, so nothing backs up.
`timescale 1ns / 1ps
`default_nettype none

module color_matrix_3x3_converter #(
   parameter int COEF_WIDTH = cmc_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = cmc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire cmc_pkg::req_type              req_data,
   output logic                               rsp_strobe,
   output cmc_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cmc_pkg::ROW_W-1:0]     csr_data
);
   import cmc_pkg::*;

   logic [ROW_W-1:0] row_ff [3];
   logic             clamp_ff;
   format_type       fmt_ff;

   logic             accept;
   logic             busy_in;
   logic             busy_ff;
   logic [7:0]       y1_in;
   logic [7:0]       y1_ff;
   vec_type          vec_in [3];
   vec_type          vec_ff [3];
   stage_type        entry_in;
   stage_type        stg_ff [4];
   logic             strobe_ff;
   logic             last_ff;
   sat_ctl_type      sat_ctl;
   logic [SAMPLE_W-1:0] chan [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW0_RESET;
         row_ff[1] <= ROW1_RESET;
         row_ff[2] <= ROW2_RESET;
         clamp_ff <= 1'b1;
         fmt_ff <= FMT_RGB;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW0:   row_ff[0] <= csr_data;
            CSR_ROW1:   row_ff[1] <= csr_data;
            CSR_ROW2:   row_ff[2] <= csr_data;
            CSR_CLAMP:  clamp_ff <= csr_data[0];
            CSR_FORMAT: fmt_ff <= format_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   assign accept = start && !busy_ff;

   // pixel entry: second uyvy pixel reuses the held chroma terms
   always_comb begin
      busy_in = 1'b0;
      y1_in = y1_ff;
      vec_in = vec_ff;
      entry_in = '{valid: 1'b0, last: 1'b1, clamp: clamp_ff, wide: 1'b0};
      if (busy_ff) begin
         vec_in[0] = $signed({9'b0, y1_ff}) - VEC_W'(LUMA_OFFSET);
         entry_in.valid = 1'b1;
      end else if (accept) begin
         case (fmt_ff)
            FMT_UYVY: begin
               vec_in[0] = $signed({9'b0, req_data.sample_1[7:0]}) - VEC_W'(LUMA_OFFSET);
               vec_in[1] = $signed({9'b0, req_data.sample_0[7:0]}) - VEC_W'(CHROMA_OFFSET);
               vec_in[2] = $signed({9'b0, req_data.sample_2[7:0]}) - VEC_W'(CHROMA_OFFSET);
               y1_in = req_data.sample_3;
               busy_in = 1'b1;
               entry_in.valid = 1'b1;
               entry_in.last = 1'b0;
            end
            FMT_RGB: begin
               vec_in[0] = $signed({9'b0, req_data.sample_0[7:0]});
               vec_in[1] = $signed({9'b0, req_data.sample_1[7:0]});
               vec_in[2] = $signed({9'b0, req_data.sample_2[7:0]});
               entry_in.valid = 1'b1;
            end
            FMT_RG48: begin
               vec_in[0] = $signed({1'b0, req_data.sample_0});
               vec_in[1] = $signed({1'b0, req_data.sample_1});
               vec_in[2] = $signed({1'b0, req_data.sample_2});
               entry_in.valid = 1'b1;
               entry_in.wide = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         strobe_ff <= 1'b0;
         for (int s = 0; s < 4; s++) begin
            stg_ff[s].valid <= 1'b0;
         end
      end else begin
         busy_ff <= busy_in;
         stg_ff[0].valid <= entry_in.valid;
         for (int s = 1; s < 4; s++) begin
            stg_ff[s].valid <= stg_ff[s-1].valid;
         end
         strobe_ff <= stg_ff[3].valid;
      end
      y1_ff <= y1_in;
      vec_ff <= vec_in;
      stg_ff[0].last <= entry_in.last;
      stg_ff[0].clamp <= entry_in.clamp;
      stg_ff[0].wide <= entry_in.wide;
      for (int s = 1; s < 4; s++) begin
         stg_ff[s].last <= stg_ff[s-1].last;
         stg_ff[s].clamp <= stg_ff[s-1].clamp;
         stg_ff[s].wide <= stg_ff[s-1].wide;
      end
      last_ff <= stg_ff[3].last;
   end

   assign sat_ctl = '{clamp: stg_ff[3].clamp, wide: stg_ff[3].wide};

   for (genvar r = 0; r < 3; r++) begin : g_chan
      cmc_channel #(
         .COEF_WIDTH (COEF_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_chan (
         .clock   (clock),
         .row     (row_ff[r]),
         .vec     (vec_ff),
         .sat_ctl (sat_ctl),
         .chan    (chan[r])
      );
   end

   assign busy = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = '{chan_0: chan[0], chan_1: chan[1], chan_2: chan[2],
                       last_of_group: last_ff};

   a_busy_after_uyvy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $past(start && !busy_ff && fmt_ff == FMT_UYVY))
      else $error("busy without a preceding uyvy transaction");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held longer than one cycle");

   a_busy_first_pixel: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (stg_ff[0].valid && !stg_ff[0].last))
      else $error("first uyvy pixel missing at entry stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && (fmt_ff == FMT_UYVY || fmt_ff == FMT_RGB || fmt_ff == FMT_RG48))
      |=> stg_ff[0].valid)
      else $error("accepted transaction did not enter pipeline");

   a_pair_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_of_group) |=> (rsp_strobe && rsp_data.last_of_group))
      else $error("second uyvy result missing");

endmodule

`default_nettype wire

// ===== bench/color_matrix_3x3_converter_test.sv =====
// color_matrix_3x3_converter_test: self-checking bench for the 3x3 color matrix converter
// depends on cmc_pkg and color_matrix_3x3_converter; predicts every pixel and compares each
// strobed result against the oldest pending prediction
`timescale 1ns / 1ps

module color_matrix_3x3_converter_test;
   import cmc_pkg::*;

   localparam int COEF_W = COEF_WIDTH_DEF;
   localparam int FRAC_W = FRAC_BITS_DEF;
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] ROW_CSR [3] = '{CSR_ROW0, CSR_ROW1, CSR_ROW2};
   localparam int PIPE_SETTLE = 8;
   localparam int DRAIN_LIMIT = 200;
   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_PIXELS = 420;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0] csr_data;

   // shadow copy of the register file
   logic [ROW_W-1:0] row_coefs [3];
   bit clamp_on;
   logic [1:0] fmt_code;

   rsp_type expected_pixels [$];
   int error_count = 0;
   int pixel_count = 0;
   int txn_count = 0;
   int write_count = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;

   color_matrix_3x3_converter dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                                 logic [COEF_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   function automatic req_type mk_pixel(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                                        logic [7:0] s3);
      req_type px;
      px.sample_0 = s0;
      px.sample_1 = s1;
      px.sample_2 = s2;
      px.sample_3 = s3;
      return px;
   endfunction

   // one output channel: exact dot product, truncate toward zero, then clamp or wrap
   function automatic logic [15:0] predict_channel(logic [ROW_W-1:0] row, longint v0, longint v1,
                                                   longint v2, bit wide);
      logic signed [COEF_W-1:0] c0;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
      longint acc;
      longint q;
      longint maxv;
      c0 = row[0 +: COEF_W];
      c1 = row[COEF_W +: COEF_W];
      c2 = row[2*COEF_W +: COEF_W];
      acc = longint'(c0) * v0 + longint'(c1) * v1 + longint'(c2) * v2;
      q = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
      maxv = wide ? MAX16 : MAX8;
      if (clamp_on) begin
         if (q < 0) q = 0;
         else if (q > maxv) q = maxv;
      end else begin
         q = q & maxv;
      end
      return q[15:0];
   endfunction

   function automatic rsp_type predict_pixel(longint v0, longint v1, longint v2, bit wide,
                                             bit last);
      rsp_type px;
      px.chan_0 = predict_channel(row_coefs[0], v0, v1, v2, wide);
      px.chan_1 = predict_channel(row_coefs[1], v0, v1, v2, wide);
      px.chan_2 = predict_channel(row_coefs[2], v0, v1, v2, wide);
      px.last_of_group = last;
      return px;
   endfunction

   task automatic forecast(req_type px);
      longint u;
      longint v;
      u = longint'(px.sample_0[7:0]) - CHROMA_OFFSET;
      v = longint'(px.sample_2[7:0]) - CHROMA_OFFSET;
      case (fmt_code)
         FMT_UYVY: begin
            expected_pixels.push_back(
               predict_pixel(longint'(px.sample_1[7:0]) - LUMA_OFFSET, u, v, 1'b0, 1'b0));
            expected_pixels.push_back(
               predict_pixel(longint'(px.sample_3) - LUMA_OFFSET, u, v, 1'b0, 1'b1));
         end
         FMT_RGB: begin
            expected_pixels.push_back(predict_pixel(longint'(px.sample_0[7:0]),
               longint'(px.sample_1[7:0]), longint'(px.sample_2[7:0]), 1'b0, 1'b1));
         end
         FMT_RG48: begin
            expected_pixels.push_back(predict_pixel(longint'(px.sample_0),
               longint'(px.sample_1), longint'(px.sample_2), 1'b1, 1'b1));
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_type random_pixel(logic [1:0] fmt);
      req_type px;
      px = mk_pixel(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      // 8-bit formats mostly get clean bytes, sometimes junk in the high byte
      if (fmt != FMT_RG48 && $urandom_range(3) != 0) begin
         px.sample_0[15:8] = '0;
         px.sample_1[15:8] = '0;
         px.sample_2[15:8] = '0;
      end
      return px;
   endfunction

   task automatic send_pixel(req_type px);
      while (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         req_data <= random_pixel(FMT_RG48);
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      forecast(px);
      txn_count++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
      while (gaps_on && $urandom_range(99) < 8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      write_count++;
      case (idx)
         CSR_ROW0: row_coefs[0] = value;
         CSR_ROW1: row_coefs[1] = value;
         CSR_ROW2: row_coefs[2] = value;
         CSR_CLAMP: clamp_on = value[0];
         CSR_FORMAT: fmt_code = value[1:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // wait for all pending pixels, then let the pipe settle; anything left is missing
   task automatic drain_pipeline;
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_SETTLE) @(posedge clock);
      while (expected_pixels.size() != 0) begin
         $display("%0t: missing pixel, expected %h", $time, expected_pixels[0]);
         error_count++;
         void'(expected_pixels.pop_front());
      end
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("chan_0", want.chan_0, rsp_data.chan_0);
            check_field("chan_1", want.chan_1, rsp_data.chan_1);
            check_field("chan_2", want.chan_2, rsp_data.chan_2);
            check_field("last_of_group", 16'(want.last_of_group), 16'(rsp_data.last_of_group));
            pixel_count++;
         end
      end
   end

   // identity matrix, clamping, RGB straight out of reset
   task automatic test_reset_defaults;
      send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00));
      send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_pixel(mk_pixel(16'h00FF, 16'hFF00, 16'h1234, 8'h5A));
      send_pixel(mk_pixel(16'h0080, 16'h007F, 16'h0001, 8'h00));
      drain_pipeline();
   endtask

   // video-range YUV to RGB, both pixels of each transaction, clamped and wrapped
   task automatic test_uyvy_levels;
      write_csr(CSR_ROW0, pack_row(16'd4768, 16'd0, 16'd6537));
      write_csr(CSR_ROW1, pack_row(16'd4768, 16'(-1606), 16'(-3330)));
      write_csr(CSR_ROW2, pack_row(16'd4768, 16'd8263, 16'd0));
      write_csr(CSR_FORMAT, 48'(FMT_UYVY));
      send_pixel(mk_pixel(16'd128, 16'd16, 16'd128, 8'd235));
      send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00));
      send_pixel(mk_pixel(16'h00FF, 16'h00FF, 16'h00FF, 8'hFF));
      send_pixel(mk_pixel(16'hFF80, 16'h1F10, 16'hAB80, 8'hEB));
      drain_pipeline();
      write_csr(CSR_CLAMP, 48'd0);
      send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00));
      send_pixel(mk_pixel(16'h00FF, 16'h0000, 16'h00FF, 8'hFF));
      drain_pipeline();
      write_csr(CSR_CLAMP, 48'd1);
   endtask

   // 16-bit samples against the largest and most negative coefficients
   task automatic test_rg48_range;
      write_csr(CSR_ROW0, pack_row(16'h7FFF, 16'h0000, 16'h0000));
      write_csr(CSR_ROW1, pack_row(16'h8000, 16'h0000, 16'h0000));
      write_csr(CSR_ROW2, pack_row(16'h1000, 16'h1000, 16'h1000));
      write_csr(CSR_FORMAT, 48'(FMT_RG48));
      send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
      send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 8'hFF));
      send_pixel(mk_pixel(16'h8000, 16'h0001, 16'hFFFF, 8'h00));
      drain_pipeline();
      write_csr(CSR_CLAMP, 48'd0);
      send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
      send_pixel(mk_pixel(16'h1234, 16'hABCD, 16'h8001, 8'h00));
      drain_pipeline();
      write_csr(CSR_CLAMP, 48'd1);
   endtask

   // unused format code takes transactions silently; high data bits and spare index ignored
   task automatic test_unused_format;
      write_csr(CSR_FORMAT, 48'hFFFF_FFFF_FFFF);
      send_pixel(mk_pixel(16'h1111, 16'h2222, 16'h3333, 8'h44));
      send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 8'h00));
      send_pixel(mk_pixel(16'h0000, 16'hFFFF, 16'h0000, 8'hFF));
      drain_pipeline();
      write_csr(CSR_SPARE, 48'h5A5A_5A5A_5A5A);
      write_csr(CSR_CLAMP, 48'hFFFF_FFFF_FFFE);
      write_csr(CSR_FORMAT, 48'hAAAA_AAAA_AAA9);
      send_pixel(mk_pixel(16'h00FF, 16'h0080, 16'h0001, 8'h00));
      send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h00FF, 8'h00));
      drain_pipeline();
   endtask

   // random matrices, clamp and format per phase, random pixels within each phase
   task automatic test_random_mix;
      int counted;
      int phase;
      int count;
      int mode;
      logic [COEF_W-1:0] c [3];
      logic [1:0] fmt;
      counted = 0;
      phase = 0;
      while (counted < RANDOM_PIXELS) begin
         gaps_on = (phase != 3);
         for (int r = 0; r < 3; r++) begin
            mode = $urandom_range(2);
            for (int k = 0; k < 3; k++) begin
               case (mode)
                  0: c[k] = COEF_W'($urandom_range(16384) - 8192);
                  1: c[k] = COEF_W'($urandom);
                  default: begin
                     case ($urandom_range(3))
                        0: c[k] = 16'h7FFF;
                        1: c[k] = 16'h8000;
                        2: c[k] = 16'h0000;
                        default: c[k] = 16'h1000;
                     endcase
                  end
               endcase
            end
            write_csr(ROW_CSR[r], pack_row(c[0], c[1], c[2]));
         end
         write_csr(CSR_CLAMP, ROW_W'({$urandom, $urandom}));
         fmt = (phase != 3 && $urandom_range(9) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
         write_csr(CSR_FORMAT, {46'($urandom), fmt});
         if (fmt == FMT_UNUSED) count = 6;
         else if (phase == 3) count = 80;
         else count = $urandom_range(20, 50);
         repeat (count) send_pixel(random_pixel(fmt));
         if (fmt != FMT_UNUSED) counted += count;
         drain_pipeline();
         phase++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ROW0;
      csr_data = '0;
      row_coefs[0] = ROW0_RESET;
      row_coefs[1] = ROW1_RESET;
      row_coefs[2] = ROW2_RESET;
      clamp_on = 1'b1;
      fmt_code = FMT_RGB;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_uyvy_levels();
      test_rg48_range();
      test_unused_format();
      test_random_mix();
      drain_pipeline();
      $display("%0d transactions sent, %0d pixels checked, %0d register writes",
               txn_count, pixel_count, write_count);
      $display("covered UYVY, RGB, RG48 and the unused format code, clamped and wrapped");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
